// ===== rtl/fevc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fevc_pkg
// Shared types and constants of the FIFO eviction key-value cache: request
// and result beats, operation codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package fevc_pkg;

  // Field widths fixed by the request and result formats
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 4;
  localparam int ENTRIES_DEF = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

  // Request operation codes
  typedef enum logic [1:0] {
    MODE_GET           = 2'd0,
    MODE_PUT           = 2'd1,
    MODE_REMOVE        = 2'd2,
    MODE_GET_OR_INSERT = 2'd3
  } mode_t;

  // One request beat
  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
  } out_beat_t;

  // Per-cell update control, driven by the top level
  typedef struct packed {
    logic take_next;    // take key and value from the younger neighbour
    logic load_new;     // store the request key and value
    logic write_value;  // overwrite the value only
  } cell_ctrl_t;

endpackage

// ===== rtl/fevc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fevc_cell
// One age position of the cache. Holds a key and a value, compares the held
// key against the lookup key and hands its contents towards the older end
// when the row shifts.
// ----------------------------------------------------------------------------
module fevc_cell (
  input  logic                    clk,
  input  fevc_pkg::cell_ctrl_t    ctrl,
  input  logic                    valid,
  input  logic                    seen_in,
  input  logic [fevc_pkg::KEY_W-1:0]   lookup_key,
  input  logic [fevc_pkg::VALUE_W-1:0] new_value,
  input  logic [fevc_pkg::KEY_W-1:0]   next_key,
  input  logic [fevc_pkg::VALUE_W-1:0] next_value,
  output logic                    match,
  output logic                    seen_out,
  output logic [fevc_pkg::KEY_W-1:0]   key,
  output logic [fevc_pkg::VALUE_W-1:0] value
);
  import fevc_pkg::*;

  logic [KEY_W-1:0]   key_r,   key_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;

  // Compare held key; pass on whether the hit lies at or before this cell
  assign match    = valid && (key_r == lookup_key);
  assign seen_out = seen_in | match;

  // Select the new contents: a fresh pair wins over a shift
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.load_new) begin
      key_nxt   = lookup_key;
      value_nxt = new_value;
    end else if (ctrl.take_next) begin
      key_nxt   = next_key;
      value_nxt = next_value;
    end else if (ctrl.write_value) begin
      value_nxt = new_value;
    end
  end

  // Hold payload; no reset needed, the valid range comes from the count
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key   = key_r;
  assign value = value_r;

endmodule

// ===== rtl/fifo_eviction_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_eviction_key_value_cache
// Fully associative key-value cache with first-in-first-out eviction, built
// as a row of cells kept in age order, oldest at cell 0.
// The result strobe rises in the cycle after the request beat is taken.
// Throughput: one request per cycle; all cells compare in parallel and the
// row shifts by one cell in the same cycle, so busy never rises.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, rst_n low) empties the cache and sets capacity to 3.
// ----------------------------------------------------------------------------
module fifo_eviction_key_value_cache #(
  parameter int ENTRIES = fevc_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  fevc_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  output fevc_pkg::out_beat_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fevc_pkg::CAP_W-1:0]   cfg_data
);
  import fevc_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_beat_t        out_data_r, out_data_nxt;

  logic               acc;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES:0]   seen;
  logic               hit;
  logic               do_insert;
  logic               do_evict;
  logic               do_remove;
  logic               do_update;
  logic [CMP_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   count_dec;
  logic [VALUE_W-1:0] hit_value;

  cell_ctrl_t         ctrl     [ENTRIES];
  logic [ENTRIES-1:0] cell_vld;
  logic [KEY_W-1:0]   cell_key [ENTRIES];
  logic [VALUE_W-1:0] cell_val [ENTRIES];

  // The row takes a beat every cycle; configuration is always taken
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // Clamp the capacity register to 1..ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  // Decode the request against the lookup result
  assign hit       = |match;
  assign do_insert = acc && !hit &&
                     ((in_data.mode == MODE_PUT) || (in_data.mode == MODE_GET_OR_INSERT));
  assign do_evict  = do_insert && (CMP_W'(count_r) >= cap_eff);
  assign do_remove = acc && hit && (in_data.mode == MODE_REMOVE);
  assign do_update = acc && hit && (in_data.mode == MODE_PUT);
  assign count_dec = count_r - CNT_W'(1);

  // Drive each cell: shift above a removed entry, or the whole row on eviction
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_vld[i]          = CNT_W'(i) < count_r;
      ctrl[i].take_next    = (do_remove && seen[i+1]) || do_evict;
      ctrl[i].load_new     = do_insert &&
                             (do_evict ? (CNT_W'(i) == count_dec) : (CNT_W'(i) == count_r));
      ctrl[i].write_value  = do_update && match[i];
    end
  end

  // Row of cells, oldest first; the youngest end takes in nothing
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_W-1:0]   nb_key;
    logic [VALUE_W-1:0] nb_val;

    if (g == ENTRIES - 1) begin : g_last
      assign nb_key = '0;
      assign nb_val = '0;
    end else begin : g_mid
      assign nb_key = cell_key[g+1];
      assign nb_val = cell_val[g+1];
    end

    fevc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .valid      (cell_vld[g]),
      .seen_in    (seen[g]),
      .lookup_key (in_data.key),
      .new_value  (in_data.value),
      .next_key   (nb_key),
      .next_value (nb_val),
      .match      (match[g]),
      .seen_out   (seen[g+1]),
      .key        (cell_key[g]),
      .value      (cell_val[g])
    );
  end

  // Select the stored value of the hit cell
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (match[i] ? cell_val[i] : '0);
    end
  end

  // Advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (do_remove) begin
      count_nxt = count_dec;
    end else if (do_insert && !do_evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Form the result beat
  always_comb begin
    out_data_nxt.hit     = hit;
    out_data_nxt.evicted = do_evict;
    if (hit) begin
      out_data_nxt.read_value = hit_value;
    end else if (in_data.mode == MODE_GET_OR_INSERT) begin
      out_data_nxt.read_value = in_data.value;
    end else begin
      out_data_nxt.read_value = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      count_r     <= count_nxt;
      out_valid_r <= acc;
    end
  end

  // Hold the result payload for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Keys are unique, so at most one cell matches
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("more than one cell matches the lookup key");

  // The count never runs past the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count beyond row length");

  // Every taken beat yields a result strobe in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("request beat without result");

  // An eviction only comes with a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted) |-> !out_data.hit)
    else $error("eviction reported on a hit");

  // The count moves only on a taken beat
  a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("entry count changed without a request");

endmodule
